### hdl/rleb_pkg.sv
`default_nettype none
package rleb_pkg;

   localparam int MAX_LITERAL = 62;
   localparam int LIT_AW      = $clog2(MAX_LITERAL);
   localparam int CNT_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int RUN_MAX     = 128;
   localparam logic [BYTE_W-1:0] LIT_BASE = 8'd128;
   localparam logic [BYTE_W-1:0] TERM_BYTE = 8'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEXT,
      ST_HDR,
      ST_BODY,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic load_item;
      logic emit_hdr;
      logic emit_body;
      logic emit_term;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic job_valid;
      logic body_final;
      logic term_pending;
   } stat_type;

endpackage
`default_nettype wire

### hdl/rleb_req_if.sv
`default_nettype none
interface rleb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

### hdl/rleb_rsp_if.sv
`default_nettype none
interface rleb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_step;
   logic       stream_done;

   modport source (output valid, output out_byte, output last_of_step, output stream_done,
                   input ready);
   modport sink   (input valid, input out_byte, input last_of_step, input stream_done,
                   output ready);
endinterface
`default_nettype wire

### hdl/rleb_ctrl.sv
`default_nettype none
module rleb_ctrl
   import rleb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (stat.job_valid) begin
               state_in = ST_HDR;
            end else if (stat.term_pending) begin
               state_in = ST_TERM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               cmd.emit_hdr = 1'b1;
               state_in     = ST_BODY;
            end
         end
         ST_BODY: begin
            if (stat.out_free) begin
               cmd.emit_body = 1'b1;
               if (stat.body_final) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_TERM: begin
            if (stat.out_free) begin
               cmd.emit_term = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hdl/rleb_datapath.sv
`default_nettype none
module rleb_datapath
   import rleb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic              req_end_of_stream,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   rleb_rsp_if.source             rsp_chan
);

   // Encoder state: count, mode and the most recent byte (run byte in run mode).
   logic [CNT_W-1:0]  cnt_ff;
   logic              in_run_ff;
   logic [BYTE_W-1:0] prev_byte_ff;

   logic [BYTE_W-1:0] lit_mem [MAX_LITERAL];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [LIT_AW-1:0] idx_ff;

   // Two-entry queue of pending emissions, slot 0 is the head.
   logic [1:0]        jv_ff;
   logic              j_run_ff  [2];
   logic [CNT_W-1:0]  j_cnt_ff  [2];
   logic [BYTE_W-1:0] j_byte_ff [2];
   logic              term_ff;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;

   logic              a_v;
   logic              a_run;
   logic [CNT_W-1:0]  a_cnt;
   logic              b_v;
   logic [CNT_W-1:0]  cnt_in;
   logic              run_in;
   logic              wr_en;
   logic [LIT_AW-1:0] wr_addr;
   logic [CNT_W-1:0]  cnt_inc;
   logic              same_byte;

   logic              body_final;
   logic              rd_en;
   logic [LIT_AW-1:0] rd_addr;
   logic [LIT_AW-1:0] idx_inc;

   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign same_byte = (req_data_byte == prev_byte_ff);

   always_comb begin
      a_v     = 1'b0;
      a_run   = 1'b0;
      a_cnt   = cnt_ff;
      wr_en   = 1'b0;
      wr_addr = cnt_ff[LIT_AW-1:0];
      cnt_in  = cnt_ff;
      run_in  = in_run_ff;
      if (in_run_ff) begin
         if (same_byte && (cnt_ff < CNT_W'(RUN_MAX))) begin
            cnt_in = cnt_inc;
         end else begin
            a_v     = 1'b1;
            a_run   = 1'b1;
            run_in  = 1'b0;
            wr_en   = 1'b1;
            wr_addr = '0;
            cnt_in  = CNT_W'(1);
         end
      end else if ((cnt_ff != '0) && same_byte) begin
         // The byte pairs with the last literal byte: flush the ones before it.
         a_v    = (cnt_ff != CNT_W'(1));
         a_cnt  = cnt_ff - CNT_W'(1);
         run_in = 1'b1;
         cnt_in = CNT_W'(2);
      end else begin
         wr_en = 1'b1;
         if (cnt_inc >= CNT_W'(MAX_LITERAL)) begin
            a_v    = 1'b1;
            a_cnt  = cnt_inc;
            cnt_in = '0;
         end else begin
            cnt_in = cnt_inc;
         end
      end
      b_v = req_end_of_stream && (run_in || (cnt_in != '0));
   end

   assign idx_inc    = idx_ff + LIT_AW'(1);
   assign body_final = j_run_ff[0] || ({{(CNT_W-LIT_AW){1'b0}}, idx_ff} ==
                                       (j_cnt_ff[0] - CNT_W'(1)));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.emit_hdr && !j_run_ff[0]) begin
         rd_en = 1'b1;
      end else if (cmd.emit_body && !body_final) begin
         rd_en   = 1'b1;
         rd_addr = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item && wr_en) begin
         lit_mem[wr_addr] <= req_data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= lit_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         in_run_ff <= 1'b0;
         jv_ff     <= '0;
         term_ff   <= 1'b0;
      end else if (cmd.load_item) begin
         cnt_ff    <= req_end_of_stream ? '0 : cnt_in;
         in_run_ff <= req_end_of_stream ? 1'b0 : run_in;
         term_ff   <= req_end_of_stream;
         jv_ff     <= a_v ? {b_v, 1'b1} : {1'b0, b_v};
      end else begin
         if (cmd.emit_body && body_final) begin
            jv_ff <= {1'b0, jv_ff[1]};
         end
         if (cmd.emit_term) begin
            term_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         prev_byte_ff <= req_data_byte;
         if (a_v) begin
            j_run_ff[0]  <= a_run;
            j_cnt_ff[0]  <= a_cnt;
            j_byte_ff[0] <= prev_byte_ff;
            j_run_ff[1]  <= run_in;
            j_cnt_ff[1]  <= cnt_in;
            j_byte_ff[1] <= req_data_byte;
         end else begin
            j_run_ff[0]  <= run_in;
            j_cnt_ff[0]  <= cnt_in;
            j_byte_ff[0] <= req_data_byte;
         end
      end else if (cmd.emit_body && body_final) begin
         j_run_ff[0]  <= j_run_ff[1];
         j_cnt_ff[0]  <= j_cnt_ff[1];
         j_byte_ff[0] <= j_byte_ff[1];
      end
      if (cmd.emit_hdr) begin
         idx_ff <= '0;
      end else if (cmd.emit_body) begin
         idx_ff <= idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_hdr || cmd.emit_body || cmd.emit_term) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_hdr) begin
         rsp_byte_ff <= j_run_ff[0] ? j_cnt_ff[0] : (LIT_BASE | j_cnt_ff[0]);
         rsp_last_ff <= 1'b0;
         rsp_done_ff <= 1'b0;
      end else if (cmd.emit_body) begin
         rsp_byte_ff <= j_run_ff[0] ? j_byte_ff[0] : rd_data_ff;
         rsp_last_ff <= body_final && !jv_ff[1] && !term_ff;
         rsp_done_ff <= 1'b0;
      end else if (cmd.emit_term) begin
         rsp_byte_ff <= TERM_BYTE;
         rsp_last_ff <= 1'b1;
         rsp_done_ff <= 1'b1;
      end
   end

   assign stat.out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign stat.job_valid    = jv_ff[0];
   assign stat.body_final   = body_final;
   assign stat.term_pending = term_ff;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = rsp_byte_ff;
   assign rsp_chan.last_of_step = rsp_last_ff;
   assign rsp_chan.stream_done  = rsp_done_ff;

endmodule
`default_nettype wire

### hdl/run_length_byte_encoder.sv
// Run-length byte encoder in the PackBits style.
// req_chan carries one raw byte per word plus an end-of-stream flag; rsp_chan
// carries the encoded bytes (headers, data bytes and the zero terminator),
// with last_of_step on the final byte caused by an input word and stream_done
// on the terminator. Both channels use a valid/ready handshake.
// A word is taken only while the encoder is idle. A word that produces no
// output passes through ST_NEXT back to idle. A word that produces output
// passes through ST_NEXT and ST_HDR before its first byte is registered; then
// one byte leaves per cycle while the receiver keeps up, with a pass through
// ST_NEXT between emission groups (a run or literal flush, then the flush at
// end of stream, then the terminator). A word holds the input until all its
// output is issued. Literal bytes are read from a buffer with separate read
// and write ports one address per cycle, the next read issued as a byte leaves.
// A result register sits on rsp_chan, so the next word can be accepted while
// the last result still waits. When the receiver stalls, emission pauses and
// the pending byte holds. Synchronous reset returns to literal mode with
// nothing buffered; the literal buffer needs no clearing.
`default_nettype none
module run_length_byte_encoder
   import rleb_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   rleb_req_if.sink   req_chan,
   rleb_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     ctl_ready;

   rleb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rleb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_chan.data_byte),
      .req_end_of_stream (req_chan.end_of_stream),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_chan          (rsp_chan)
   );

   assign req_chan.ready = ctl_ready;

   // While a word can be taken, nothing of the previous word may still be queued.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      ctl_ready |-> (!stat.job_valid && !stat.term_pending))
      else $error("encoder ready with emissions still pending");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.stream_done) |-> rsp_chan.last_of_step)
      else $error("terminator not marked as last of step");

   a_term_order: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_term |-> !stat.job_valid)
      else $error("terminator issued before flush completed");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.emit_hdr, cmd.emit_body, cmd.emit_term}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire
